### sv/aqs_pkg.sv
`default_nettype none
package aqs_pkg;
   localparam int CompFracBits = 15;
   localparam int IntFracBits  = 24;

   // Q32 constants
   localparam longint KAtten = 64'sd3533885648;
   localparam longint KSlope = 64'sd2514669808;
   localparam longint KNb    = 64'sd4119157105;
   localparam longint KAdd   = 64'sd4387034215;
   localparam longint KFact  = 64'sd2287134510;
   localparam longint KThr1  = 64'sd3930805523;
   localparam longint KThr2  = 64'sd2800832785;

   // scale a Q32 constant to the internal format, halves up
   function automatic longint qc(input longint q32, input int f);
      if (f >= 32) return q32 <<< (f - 32);
      return (q32 + (64'sd1 <<< (31 - f))) >>> (32 - f);
   endfunction
endpackage
`default_nettype wire

### sv/approx_quaternion_slerp_top.sv
`default_nettype none
// Fast approximate quaternion slerp, fixed point.
// Pipeline: 20 register stages, s0 to s19; rsp is driven from the last stage.
// Throughput: one item per cycle unless stalled; a stall on a valid rsp freezes the whole
// pipeline and stalls req in the same cycle.
// Reset: synchronous, clears all stage valid bits; payload is not reset.
module approx_quaternion_slerp_top #(
   parameter int COMPONENT_FRAC_BITS = aqs_pkg::CompFracBits,
   parameter int INTERNAL_FRAC_BITS  = aqs_pkg::IntFracBits
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [16:0] req_weight,
   input  wire logic signed [15:0] req_from_w,
   input  wire logic signed [15:0] req_from_x,
   input  wire logic signed [15:0] req_from_y,
   input  wire logic signed [15:0] req_from_z,
   input  wire logic signed [15:0] req_to_w,
   input  wire logic signed [15:0] req_to_x,
   input  wire logic signed [15:0] req_to_y,
   input  wire logic signed [15:0] req_to_z,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [15:0] rsp_out_w,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z
);
   import aqs_pkg::*;
   localparam int F  = INTERNAL_FRAC_BITS;
   // internal word: eight integer bits, live values stay within +-20
   localparam int W  = INTERNAL_FRAC_BITS + 8;
   localparam int NS = 20;

   typedef logic signed [W-1:0] iw_type;

   // pipeline state: one bundle per stage
   typedef struct packed {
      iw_type a0, a1, a2, a3, b0, b1, b2, b3;
      iw_type t, c, x0, x1, k, s;
      logic   mir;
   } st_type;

   logic   en;
   logic   v_ff [NS];
   st_type d_ff [NS];
   st_type d_in [NS];

   // whole-pipe stall: output stage holds when stalled
   assign en        = !(rsp_stall && v_ff[NS-1]);
   assign req_stall = !en;

   // rounded Q product, halves away from zero, saturating to W
   function automatic iw_type mulq(input iw_type a, input iw_type b);
      logic [W-1:0]   ua, ub, m;
      logic [2*W-1:0] p, r;
      logic           neg;
      neg = a[W-1] ^ b[W-1];
      ua = a[W-1] ? W'(-a) : W'(a);
      ub = b[W-1] ? W'(-b) : W'(b);
      p = (2*W)'(ua) * (2*W)'(ub);
      r = (p + ((2*W)'(1) << (F - 1))) >> F;
      if (r > (2*W)'({1'b0, {(W-1){1'b1}}})) m = {1'b0, {(W-1){1'b1}}};
      else m = r[W-1:0];
      return neg ? iw_type'(-m) : iw_type'(m);
   endfunction

   // g(s) = ADD - (s - NB) * FACT
   function automatic iw_type isq(input iw_type s);
      iw_type d;
      d = s - iw_type'(qc(KNb, F));
      return iw_type'(qc(KAdd, F)) - mulq(d, iw_type'(qc(KFact, F)));
   endfunction

   function automatic iw_type cin(input logic signed [15:0] v);
      iw_type e;
      e = iw_type'(v);
      if (F >= COMPONENT_FRAC_BITS) return e <<< (F - COMPONENT_FRAC_BITS);
      return (e + (iw_type'(1) <<< (COMPONENT_FRAC_BITS - F - 1)))
             >>> (COMPONENT_FRAC_BITS - F);
   endfunction

   // the internal word is far below the 2^(F+20) clamp, so only the
   // 16-bit saturation can act
   function automatic logic [15:0] cout(input iw_type v);
      iw_type r;
      if (F >= COMPONENT_FRAC_BITS)
         r = (v + (iw_type'(1) <<< (F - COMPONENT_FRAC_BITS - 1)))
             >>> (F - COMPONENT_FRAC_BITS);
      else r = v <<< (COMPONENT_FRAC_BITS - F);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   localparam iw_type One  = iw_type'(1) <<< F;
   localparam iw_type Half = iw_type'(1) <<< (F - 1);

   // stage logic, one multiply level per stage
   always_comb begin
      st_type      p;
      iw_type      t;
      logic [16:0] w;
      // s0: convert, saturate weight, fold
      p = '0;
      w = (req_weight > 17'd65536) ? 17'd65536 : req_weight;
      t = iw_type'(w) <<< (F - 16);
      p.a0 = cin(req_from_w); p.a1 = cin(req_from_x);
      p.a2 = cin(req_from_y); p.a3 = cin(req_from_z);
      p.b0 = cin(req_to_w);   p.b1 = cin(req_to_x);
      p.b2 = cin(req_to_y);   p.b3 = cin(req_to_z);
      p.mir = t > Half;
      p.t = p.mir ? One - t : t;
      d_in[0] = p;
      // s1: dot product
      p = d_ff[0];
      p.c = mulq(p.a0, p.b0) + mulq(p.a1, p.b1)
          + mulq(p.a2, p.b2) + mulq(p.a3, p.b3);
      d_in[1] = p;
      // s2: f = 1 - ATTEN*c
      p = d_ff[1];
      p.x0 = One - mulq(iw_type'(qc(KAtten, F)), p.c);
      d_in[2] = p;
      // s3: f*f
      p = d_ff[2];
      p.x0 = mulq(p.x0, p.x0);
      d_in[3] = p;
      // s4: k = SLOPE*f*f
      p = d_ff[3];
      p.k = mulq(iw_type'(qc(KSlope, F)), p.x0);
      d_in[4] = p;
      // s5: k*u
      p = d_ff[4];
      p.x1 = mulq(p.k, p.t);
      d_in[5] = p;
      // s6: k*u*(2u-3) + 1 + k
      p = d_ff[5];
      p.x1 = mulq(p.x1, (p.t <<< 1) - One - (One <<< 1)) + One + p.k;
      d_in[6] = p;
      // s7: warped weight, unfold
      p = d_ff[6];
      p.x0 = mulq(p.t, p.x1);
      p.x0 = p.mir ? One - p.x0 : p.x0;
      d_in[7] = p;
      // s8: blend
      p = d_ff[7];
      p.a0 = p.a0 + mulq(p.x0, p.b0 - p.a0);
      p.a1 = p.a1 + mulq(p.x0, p.b1 - p.a1);
      p.a2 = p.a2 + mulq(p.x0, p.b2 - p.a2);
      p.a3 = p.a3 + mulq(p.x0, p.b3 - p.a3);
      d_in[8] = p;
      // s9: squared length
      p = d_ff[8];
      p.s = mulq(p.a0, p.a0) + mulq(p.a1, p.a1)
          + mulq(p.a2, p.a2) + mulq(p.a3, p.a3);
      d_in[9] = p;
      // s10: first estimate
      p = d_ff[9];
      p.k = isq(p.s);
      d_in[10] = p;
      // s11..s14: first refinement
      p = d_ff[10];
      p.x1 = mulq(p.k, p.k);
      d_in[11] = p;
      p = d_ff[11];
      p.x1 = mulq(p.x1, p.s);
      d_in[12] = p;
      p = d_ff[12];
      p.x1 = isq(p.x1);
      d_in[13] = p;
      p = d_ff[13];
      if (p.s <= iw_type'(qc(KThr1, F)))
         p.k = mulq(p.k, p.x1);
      d_in[14] = p;
      // s15..s18: second refinement, only inside the second threshold
      p = d_ff[14];
      p.x1 = mulq(p.k, p.k);
      d_in[15] = p;
      p = d_ff[15];
      p.x1 = mulq(p.x1, p.s);
      d_in[16] = p;
      p = d_ff[16];
      p.x1 = isq(p.x1);
      d_in[17] = p;
      p = d_ff[17];
      if (p.s <= iw_type'(qc(KThr2, F)))
         p.k = mulq(p.k, p.x1);
      d_in[18] = p;
      // s19: scale
      p = d_ff[18];
      p.a0 = mulq(p.a0, p.k); p.a1 = mulq(p.a1, p.k);
      p.a2 = mulq(p.a2, p.k); p.a3 = mulq(p.a3, p.k);
      d_in[19] = p;
   end

   for (genvar g = 0; g < NS; g++) begin : g_st
      aqs_stage #(.W($bits(st_type))) u_st (
         .clock(clock), .reset(reset), .en(en),
         .v_in((g == 0) ? req_valid : v_ff[g == 0 ? 0 : g-1]),
         .d_in(d_in[g]), .v_ff(v_ff[g]), .d_ff(d_ff[g])
      );
   end

   assign rsp_valid = v_ff[NS-1];
   assign rsp_out_w = cout(d_ff[NS-1].a0);
   assign rsp_out_x = cout(d_ff[NS-1].a1);
   assign rsp_out_y = cout(d_ff[NS-1].a2);
   assign rsp_out_z = cout(d_ff[NS-1].a3);

   // stall holds the output item
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_w))
      else $error("output item changed under stall");
   // input stall only when output is stalled
   a_stl: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("spurious input stall");
endmodule
`default_nettype wire

### sv/aqs_stage.sv
`default_nettype none
// one pipeline register stage with stall
module aqs_stage #(
   parameter int W = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         v_in,
   input  wire logic [W-1:0] d_in,
   output logic              v_ff,
   output logic [W-1:0]      d_ff
);
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= v_in;
      end
      if (en) begin
         d_ff <= d_in;
      end
   end
endmodule
`default_nettype wire

### dv/tb_approx_quaternion_slerp_top.sv
`default_nettype none
module tb_approx_quaternion_slerp_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  FB       = aqs_pkg::IntFracBits;
   localparam int  CB       = aqs_pkg::CompFracBits;
   localparam int  LATENCY  = 20;
   localparam int  WD_LIMIT = 5000;
   localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [16:0]        weight;
      logic signed [15:0] a [4];
      logic signed [15:0] b [4];
   } pair_type;

   typedef struct {
      logic signed [15:0] q [4];
   } quat_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [16:0] req_weight;
   logic signed [15:0] req_from_w, req_from_x, req_from_y, req_from_z;
   logic signed [15:0] req_to_w, req_to_x, req_to_y, req_to_z;
   logic rsp_valid, rsp_stall;
   logic signed [15:0] rsp_out_w, rsp_out_x, rsp_out_y, rsp_out_z;

   quat_type  blend_queue [$];
   int     mismatches, checked, sent, idle_cycles;
   bit     no_idle;
   int     long_hold;

   approx_quaternion_slerp_top u_dut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- fixed-point predictor ----------------
   // floor shift after adding half an lsb
   function automatic longint shr_round(input longint v, input int n);
      if (n <= 0) return v;
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint fix_const(input longint q32);
      if (FB >= 32) return q32 <<< (FB - 32);
      return shr_round(q32, 32 - FB);
   endfunction

   // rounded product, halves away from zero, saturating magnitude
   function automatic longint fix_mul(input longint a, input longint b);
      logic [63:0]  ua, ub;
      logic [127:0] p;
      logic [63:0]  m;
      bit neg;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? 64'(-a) : 64'(a);
      ub = (b < 0) ? 64'(-b) : 64'(b);
      p = (128'(ua) * 128'(ub) + (128'd1 << (FB - 1))) >> FB;
      if (p > 128'(I64_MAX)) m = 64'(I64_MAX);
      else m = p[63:0];
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint comp_to_fix(input logic signed [15:0] c);
      longint v;
      v = c;
      if (FB >= CB) return v <<< (FB - CB);
      return shr_round(v, CB - FB);
   endfunction

   function automatic logic signed [15:0] fix_to_comp(input longint v);
      longint lim, r;
      lim = 64'sd1 <<< (FB + 20);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      r = (FB >= CB) ? shr_round(v, FB - CB) : v <<< (CB - FB);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   // cubic weight correction
   function automatic longint warp_weight(input longint u, input longint c);
      longint one, f, k;
      one = 64'sd1 <<< FB;
      f = one - fix_mul(fix_const(aqs_pkg::KAtten), c);
      f = fix_mul(f, f);
      k = fix_mul(fix_const(aqs_pkg::KSlope), f);
      return fix_mul(u, fix_mul(fix_mul(k, u), 2 * u - 3 * one) + one + k);
   endfunction

   // linear inverse-square-root estimate
   function automatic longint inv_sqrt_est(input longint s);
      return fix_const(aqs_pkg::KAdd) - fix_mul(s - fix_const(aqs_pkg::KNb),
                                                 fix_const(aqs_pkg::KFact));
   endfunction

   function automatic quat_type slerp_predict(input pair_type p);
      longint one, t, tp, c, s, k;
      longint a [4], b [4], r [4];
      quat_type o;
      one = 64'sd1 <<< FB;
      t = (p.weight > 17'd65536) ? 65536 : longint'(p.weight);
      t = t <<< (FB - 16);
      c = 0;
      s = 0;
      for (int i = 0; i < 4; i++) begin
         a[i] = comp_to_fix(p.a[i]);
         b[i] = comp_to_fix(p.b[i]);
         c += fix_mul(a[i], b[i]);
      end
      if (t <= (64'sd1 <<< (FB - 1))) tp = warp_weight(t, c);
      else tp = one - warp_weight(one - t, c);
      for (int i = 0; i < 4; i++) begin
         r[i] = a[i] + fix_mul(tp, b[i] - a[i]);
         s += fix_mul(r[i], r[i]);
      end
      k = inv_sqrt_est(s);
      if (s <= fix_const(aqs_pkg::KThr1)) begin
         k = fix_mul(k, inv_sqrt_est(fix_mul(fix_mul(k, k), s)));
         if (s <= fix_const(aqs_pkg::KThr2))
            k = fix_mul(k, inv_sqrt_est(fix_mul(fix_mul(k, k), s)));
      end
      for (int i = 0; i < 4; i++) o.q[i] = fix_to_comp(fix_mul(r[i], k));
      return o;
   endfunction

   // ---------------- sender ----------------
   task automatic send_pair(input pair_type p);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_weight <= p.weight;
      req_from_w <= p.a[0]; req_from_x <= p.a[1];
      req_from_y <= p.a[2]; req_from_z <= p.a[3];
      req_to_w   <= p.b[0]; req_to_x   <= p.b[1];
      req_to_y   <= p.b[2]; req_to_z   <= p.b[3];
      req_valid  <= 1'b1;
      do @(posedge clock); while (req_stall);
      blend_queue.push_back(slerp_predict(p));
      sent++;
      @(negedge clock);
   endtask

   // ---------------- receiver stalls ----------------
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold > 0) begin
            n = long_hold;
            long_hold = 0;
         end else begin
            n = no_idle ? 0 : $urandom_range(0, 9);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // ---------------- result check ----------------
   always @(posedge clock) begin
      quat_type e;
      logic signed [15:0] got [4];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_out_w, rsp_out_x, rsp_out_y, rsp_out_z};
         checked++;
         if (blend_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
         end else begin
            e = blend_queue.pop_front();
            for (int i = 0; i < 4; i++) begin
               if (got[i] !== e.q[i]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch comp %0d at %0t: expected %0d got %0d",
                              i, $realtime, e.q[i], got[i]);
               end
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("watchdog timeout, %0d results pending", blend_queue.size());
         $display("approx_quaternion_slerp_top verification failed");
         $finish;
      end
   end

   // ---------------- stimulus helpers ----------------
   function automatic pair_type make_pair(input int w,
                                          input int a0, a1, a2, a3,
                                          input int b0, b1, b2, b3);
      pair_type p;
      p.weight = 17'(w);
      p.a = '{16'(a0), 16'(a1), 16'(a2), 16'(a3)};
      p.b = '{16'(b0), 16'(b1), 16'(b2), 16'(b3)};
      return p;
   endfunction

   // random unit quaternion, scaled to Q1.15
   task automatic rand_unit(output logic signed [15:0] q [4]);
      real v [4];
      real n;
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
         v[i] = real'($urandom_range(0, 20000)) - 10000.0;
         n += v[i] * v[i];
      end
      if (n == 0.0) begin
         v[0] = 1.0;
         n = 1.0;
      end
      n = $sqrt(n);
      for (int i = 0; i < 4; i++) q[i] = 16'($rtoi(v[i] / n * 32767.0));
   endtask

   task automatic rand_pair(output pair_type p);
      int kind;
      kind = $urandom_range(0, 9);
      rand_unit(p.a);
      rand_unit(p.b);
      if (kind == 0) begin
         // raw noise, any bit pattern
         p.weight = 17'($urandom);
         for (int i = 0; i < 4; i++) begin
            p.a[i] = 16'($urandom);
            p.b[i] = 16'($urandom);
         end
      end else begin
         if (kind <= 3) begin
            // nearby target: high dot product
            for (int i = 0; i < 4; i++)
               p.b[i] = p.a[i] + 16'($signed($urandom_range(0, 4000)) - 2000);
         end else if (kind == 4) begin
            for (int i = 0; i < 4; i++) p.b[i] = -p.a[i];
         end
         p.weight = (kind == 5) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      end
   endtask

   // ---------------- tests ----------------
   task automatic test_directed();
      int u;
      u = 32767;
      send_pair(make_pair(0,      u, 0, 0, 0,  0, u, 0, 0));
      send_pair(make_pair(65536,  u, 0, 0, 0,  0, u, 0, 0));
      send_pair(make_pair(32768,  u, 0, 0, 0,  0, u, 0, 0));
      send_pair(make_pair(32769,  u, 0, 0, 0,  0, 0, u, 0));
      send_pair(make_pair(32767,  u, 0, 0, 0,  0, 0, 0, u));
      // weight above one saturates
      send_pair(make_pair(65537,  u, 0, 0, 0,  0, u, 0, 0));
      send_pair(make_pair(131071, 0, 0, u, 0,  0, 0, 0, u));
      // identical inputs
      send_pair(make_pair(20000,  16384, 16384, 16384, 16384,
                                  16384, 16384, 16384, 16384));
      // opposite inputs: negative dot, blend through zero
      send_pair(make_pair(32768,  u, 0, 0, 0,  -u, 0, 0, 0));
      send_pair(make_pair(16000,  0, u, 0, 0,  0, -u, 0, 0));
      // zero blend
      send_pair(make_pair(12345,  0, 0, 0, 0,  0, 0, 0, 0));
      send_pair(make_pair(32768,  1000, -2000, 3000, -4000,
                                  -1000, 2000, -3000, 4000));
      // non-unit extremes, saturation
      send_pair(make_pair(0,      -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768, -32768));
      send_pair(make_pair(65536,  32767, 32767, 32767, 32767,
                                  32767, 32767, 32767, 32767));
      send_pair(make_pair(40000,  32767, -32768, 32767, -32768,
                                  -32768, 32767, -32768, 32767));
      // tiny quaternions exercise both refinement passes
      send_pair(make_pair(10000,  1, 0, 0, 0,  0, 1, 0, 0));
      send_pair(make_pair(50000,  20000, 0, 0, 0,  0, 20000, 0, 0));
      send_pair(make_pair(30000,  27000, 0, 0, 0,  0, 27000, 0, 0));
   endtask

   task automatic test_random(input int count);
      pair_type p;
      for (int i = 0; i < count; i++) begin
         // occasional bursts with no idling on either side
         if (i % 300 == 0) no_idle = 1'b1;
         if (i % 300 == 60) no_idle = 1'b0;
         rand_pair(p);
         send_pair(p);
      end
      no_idle = 1'b0;
   endtask

   // receiver holds off long while the sender keeps offering
   task automatic test_backpressure();
      pair_type p;
      no_idle = 1'b1;
      long_hold = 150;
      for (int i = 0; i < 80; i++) begin
         rand_pair(p);
         send_pair(p);
      end
      no_idle = 1'b0;
   endtask

   // ---------------- main ----------------
   initial begin
      int wait_cnt;
      reset = 1'b1;
      req_valid = 1'b0;
      req_weight = '0;
      {req_from_w, req_from_x, req_from_y, req_from_z} = '0;
      {req_to_w, req_to_x, req_to_y, req_to_z} = '0;
      mismatches = 0; checked = 0; sent = 0; idle_cycles = 0;
      no_idle = 1'b0; long_hold = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_backpressure();
      test_random(1850);

      req_valid <= 1'b0;
      wait_cnt = 0;
      while (blend_queue.size() != 0 && wait_cnt < WD_LIMIT) begin
         @(negedge clock);
         wait_cnt++;
      end
      repeat (LATENCY + 8) @(negedge clock);

      $display("sent %0d items (directed corners, unit and noise pairs, long hold-off),",
               sent);
      $display("checked %0d results, %0d mismatches", checked, mismatches);
      if (mismatches == 0 && blend_queue.size() == 0) begin
         $display("approx_quaternion_slerp_top verification clean");
      end else begin
         $display("approx_quaternion_slerp_top verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
